### rtl/bfiq_pkg.sv
// Shared types and constants for the Bloom filter insert/query core.
// No dependencies; imported by every module of the block.
`default_nettype none

package bfiq_pkg;

    // Field and datapath widths
    localparam int HASH_W  = 32;
    localparam int MODE_W  = 2;
    localparam int IDX_W   = 12;
    localparam int FB_W    = 13;   // filter_bytes register
    localparam int HC_W    = 8;    // hash_count register
    localparam int NBITS_W = 16;   // filter size in bits, at most 8191*8
    localparam int CNT_W   = 17;   // byte counts up to the largest store
    localparam int PROBE_W = 5;
    localparam int STEP_W  = 5;    // one remainder bit per step

    // Hashing constants
    localparam int ROT_RIGHT   = 17;
    localparam int PROBE_LIMIT = 30;
    localparam int MIN_BYTES   = 8;

    // Item kinds
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT   = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [HASH_W-1:0] key_hash;
        logic [IDX_W-1:0]  byte_index;
    } t_in_item;

    typedef struct packed {
        logic       may_match;
        logic [7:0] data_byte;
    } t_out_item;

    // Controller to datapath strobes
    typedef struct packed {
        logic load;      // latch the item, start remainder of the first probe
        logic clr_step;  // zero one store byte, advance the sweep address
        logic div_step;  // one remainder bit
        logic rd_byte;   // read address comes from byte_index
        logic upd;       // set or test the probed bit, step the hash
        logic cap_byte;  // capture the byte for a read item
        logic push;      // load the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [PROBE_W-1:0] probes;     // min(hash_count, 30)
        logic               over_limit; // hash_count above 30
        logic               bit_set;    // probed bit in the read byte
        logic               clr_last;   // sweep at the last byte
        logic               out_free;   // output register can take a result
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/bfiq_dpath.sv
// Datapath: config registers, item latch, bit-serial remainder unit,
// byte store with registered read, and the output register. Uses bfiq_pkg.
`default_nettype none

module bfiq_dpath
    import bfiq_pkg::*;
#(
    parameter int MAX_BYTES = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_in_item             i_in_data,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [FB_W-1:0]      i_cfg_wdata,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam logic [CNT_W-1:0] MaxBytesW = CNT_W'(MAX_BYTES);
    localparam logic [CNT_W-1:0] MinBytesW = CNT_W'(MIN_BYTES);
    localparam logic [AW-1:0]    LastAddr  = AW'(MAX_BYTES - 1);

    logic [FB_W-1:0]    r_filter_bytes;
    logic [HC_W-1:0]    r_hash_count;
    t_in_item           r_item;
    logic [HASH_W-1:0]  r_h;
    logic [HASH_W-1:0]  r_delta;
    logic [HASH_W-1:0]  r_shift;
    logic [NBITS_W-1:0] r_rem;
    logic [NBITS_W-1:0] r_nbits;
    logic               r_match;
    logic [7:0]         r_byte;
    logic [AW-1:0]      r_clr;
    logic [7:0]         r_rdata;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [7:0]         mem [0:MAX_BYTES-1];

    logic [CNT_W-1:0]   fb_w;
    logic [CNT_W-1:0]   eff_bytes;
    logic [CNT_W+2:0]   nbits_full;
    logic [HASH_W-1:0]  n_h;
    logic [HASH_W-1:0]  key_delta;
    logic [NBITS_W:0]   rem_sh;
    logic [NBITS_W:0]   rem_diff;
    logic [NBITS_W-1:0] n_rem;
    logic [7:0]         mask;
    logic [CNT_W-1:0]   probe_addr_w;
    logic [CNT_W-1:0]   idx_w;
    logic [CNT_W-1:0]   raddr_w;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic [7:0]         wdata;
    logic               we;
    logic               is_insert;
    logic               is_query;

    // Effective size: clamp to [MIN_BYTES, MAX_BYTES], bit count is eight times that
    assign fb_w       = CNT_W'(r_filter_bytes);
    assign eff_bytes  = (fb_w < MinBytesW) ? MinBytesW :
                        ((fb_w > MaxBytesW) ? MaxBytesW : fb_w);
    assign nbits_full = {eff_bytes, 3'b000};

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_bytes <= FB_W'(MIN_BYTES);
            r_hash_count   <= HC_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FILTER_BYTES: r_filter_bytes <= i_cfg_wdata;
                CFG_HASH_COUNT:   r_hash_count   <= i_cfg_wdata[HC_W-1:0];
                default:          r_filter_bytes <= r_filter_bytes;
            endcase
        end
    end

    assign is_insert = (r_item.mode == MODE_INSERT);
    assign is_query  = (r_item.mode == MODE_QUERY);

    // Delta is the key hash rotated right
    assign key_delta = {i_in_data.key_hash[ROT_RIGHT-1:0],
                        i_in_data.key_hash[HASH_W-1:ROT_RIGHT]};
    assign n_h       = r_h + r_delta;

    // Restoring remainder, one dividend bit per step
    assign rem_sh   = {r_rem, r_shift[HASH_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_nbits};
    assign n_rem    = (rem_sh >= {1'b0, r_nbits}) ? rem_diff[NBITS_W-1:0]
                                                  : rem_sh[NBITS_W-1:0];

    // Hash state and remainder unit
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_in_data;
            r_h     <= i_in_data.key_hash;
            r_delta <= key_delta;
            r_shift <= i_in_data.key_hash;
            r_rem   <= '0;
            r_nbits <= nbits_full[NBITS_W-1:0];
        end else if (i_cmd.div_step) begin
            r_shift <= {r_shift[HASH_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end else if (i_cmd.upd) begin
            r_h     <= n_h;
            r_shift <= n_h;
            r_rem   <= '0;
        end
    end

    // Query verdict and read-byte result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_match <= 1'b1;
            r_byte  <= '0;
        end else begin
            if (i_cmd.upd && is_query && ((r_rdata & mask) == 8'd0)) begin
                r_match <= 1'b0;
            end
            if (i_cmd.cap_byte) begin
                r_byte <= (idx_w < eff_bytes) ? r_rdata : 8'd0;
            end
        end
    end

    // Store addressing
    assign mask         = 8'(1) << r_rem[2:0];
    assign probe_addr_w = CNT_W'(r_rem[NBITS_W-1:3]);
    assign idx_w        = CNT_W'(r_item.byte_index);
    assign raddr_w      = i_cmd.rd_byte ? idx_w : probe_addr_w;
    assign raddr        = raddr_w[AW-1:0];
    assign we           = i_cmd.clr_step || (i_cmd.upd && is_insert);
    assign waddr        = i_cmd.clr_step ? r_clr : probe_addr_w[AW-1:0];
    assign wdata        = i_cmd.clr_step ? 8'd0 : (r_rdata | mask);

    // Clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= (r_clr == LastAddr) ? '0 : r_clr + AW'(1);
        end
    end

    // Byte store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out.may_match <= r_match && is_query;
            r_out.data_byte <= r_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status
    assign o_stat.mode       = r_item.mode;
    assign o_stat.over_limit = (r_hash_count > HC_W'(PROBE_LIMIT));
    assign o_stat.probes     = o_stat.over_limit ? PROBE_W'(PROBE_LIMIT)
                                                 : r_hash_count[PROBE_W-1:0];
    assign o_stat.bit_set    = ((r_rdata & mask) != 8'd0);
    assign o_stat.clr_last   = (r_clr == LastAddr);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire

### rtl/bfiq_ctrl.sv
// Controller: sequences clearing sweeps, probe loops and byte reads, and
// counts remainder steps and probes. Uses bfiq_pkg.
`default_nettype none

module bfiq_ctrl
    import bfiq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [9:0] {
        S_INIT   = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_DECODE = 10'b0000000100,
        S_DIV    = 10'b0000001000,
        S_READ   = 10'b0000010000,
        S_UPDATE = 10'b0000100000,
        S_RDB    = 10'b0001000000,
        S_RDW    = 10'b0010000000,
        S_CLEAR  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    localparam logic [STEP_W-1:0] StepLast = STEP_W'(HASH_W - 1);

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [PROBE_W-1:0] r_probe, n_probe;
    logic               probe_last;
    logic               miss;

    assign probe_last = ((r_probe + PROBE_W'(1)) == i_stat.probes);
    assign miss       = (i_stat.mode == MODE_QUERY) && !i_stat.bit_set;

    // Next state and command strobes
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_probe = r_probe;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_step  = '0;
                n_probe = '0;
                unique case (i_stat.mode)
                    MODE_CLEAR: n_state = S_CLEAR;
                    MODE_INSERT: begin
                        n_state = (i_stat.probes == '0) ? S_DONE : S_DIV;
                    end
                    MODE_QUERY: begin
                        n_state = (i_stat.probes == '0 || i_stat.over_limit) ? S_DONE
                                                                              : S_DIV;
                    end
                    MODE_READ:  n_state = S_RDB;
                    default:    n_state = S_DONE;
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == StepLast) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.upd = 1'b1;
                n_step    = '0;
                n_probe   = r_probe + PROBE_W'(1);
                n_state   = (miss || probe_last) ? S_DONE : S_DIV;
            end
            S_RDB: begin
                o_cmd.rd_byte = 1'b1;
                n_state       = S_RDW;
            end
            S_RDW: begin
                o_cmd.cap_byte = 1'b1;
                n_state        = S_DONE;
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_step  <= '0;
            r_probe <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_probe <= n_probe;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

### rtl/bloom_filter_insert_query_core.sv
// Top level of the Bloom filter insert/query core: controller plus datapath.
// Depends on bfiq_pkg, bfiq_ctrl and bfiq_dpath.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+---------------------------
//   in       | input     | i_in_valid / o_in_stall  | i_in_data  (t_in_item)
//   out      | output    | o_out_valid / i_out_stall| o_out_data (t_out_item)
//   cfg      | input     | i_cfg_we                 | i_cfg_idx, i_cfg_wdata
//
// Insert runs k = min(hash_count, 30) probes; a query runs k = hash_count probes,
// or none when hash_count is above 30. Each probe runs the bit-serial remainder
// unit for 32 steps, then a store read and an update; a query stops at its first
// zero bit. Clear zeroes all MAX_BYTES store bytes, one per cycle.
// After reset a clearing pass over every store byte runs with o_in_stall high.
// A result waiting on i_out_stall does not block the next input transfer.
`default_nettype none

module bloom_filter_insert_query_core
    import bfiq_pkg::*;
#(
    parameter int MAX_BYTES = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [FB_W-1:0]      i_cfg_wdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bfiq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bfiq_dpath #(
        .MAX_BYTES (MAX_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

    // A result never overwrites one that is still held by the sink
    a_no_push_over_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !cmd.push)
        else $error("result pushed over a held output");

    // Controller issues at most one datapath operation per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.clr_step, cmd.div_step, cmd.rd_byte,
                  cmd.upd, cmd.cap_byte, cmd.push}))
        else $error("overlapping datapath commands");

    // An input transfer closes the input side on the next cycle
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after a transfer");

    // A query answer never carries a store byte
    a_match_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.may_match) |-> (o_out_data.data_byte == 8'd0))
        else $error("match result with nonzero data byte");

endmodule

`default_nettype wire
